### hdl/cbfm_pkg.sv
package cbfm_pkg;

	localparam int NUM_FRAMES     = 16;
	localparam int FILE_ID_BITS   = 8;
	localparam int PIN_COUNT_BITS = 8;
	localparam int FRAME_BITS     = $clog2(NUM_FRAMES);
	localparam int CFG_BITS       = 5;
	localparam int PAGE_BITS      = 32;
	localparam int OUT_FILE_BITS  = 8;
	localparam int OUT_FRAME_BITS = 4;
	localparam int STEP_BITS      = FRAME_BITS + 2;

	localparam logic [CFG_BITS-1:0]       NF_CFG  = CFG_BITS'(NUM_FRAMES);
	localparam logic [PIN_COUNT_BITS-1:0] PIN_MAX = '1;

	typedef enum logic [2:0] {
		CMD_READ    = 3'd0,
		CMD_UNPIN   = 3'd1,
		CMD_ALLOC   = 3'd2,
		CMD_DISPOSE = 3'd3,
		CMD_FLUSH   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EXCEEDED = 2'd1,
		ST_NOT_PIN  = 2'd2,
		ST_PINNED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_SWEEP,
		S_FLUSH,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch command fields
		logic scan_clr;  // reset scan index
		logic look_step; // test one frame for a tag match
		logic sweep_step;
		logic flush_step;
		logic act_hit;   // apply read/unpin/dispose on matched frame
		logic act_miss;  // unpin/dispose with no match
		logic act_load;  // load victim, emit result
		logic act_full;  // emit buffer exceeded
		logic act_unk;   // emit empty result
		logic flush_done; // emit the held flush result with last
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic       found;     // lookup found a match
		logic       look_end;  // lookup is at the last frame
		logic       taken;     // sweep takes the current frame
		logic       sweep_end; // sweep reached its step limit
		logic       flush_stop;
		logic       flush_last;
		logic [2:0] cmd;
	} sts_t;

endpackage

### hdl/cbfm_ctrl.sv
module cbfm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cbfm_pkg::sts_t sts,
	output cbfm_pkg::ctl_t ctl
);
	import cbfm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				case (sts.cmd)
					CMD_ALLOC: state_d = S_SWEEP;
					CMD_FLUSH: state_d = S_FLUSH;
					CMD_READ: begin
						if (sts.found) state_d = S_IDLE;
						else if (sts.look_end) state_d = S_SWEEP;
					end
					CMD_UNPIN, CMD_DISPOSE: begin
						if (sts.found || sts.look_end) state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SWEEP: begin
				if (sts.taken || sts.sweep_end) state_d = S_IDLE;
			end
			S_FLUSH: begin
				if (sts.flush_stop || sts.flush_last) state_d = S_DONE;
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				ctl.capture  = start;
				ctl.scan_clr = start;
			end
			S_LOOKUP: begin
				case (sts.cmd)
					CMD_READ, CMD_UNPIN, CMD_DISPOSE: begin
						ctl.look_step = 1'b1;
						ctl.act_hit   = sts.found;
						ctl.act_miss  = !sts.found && sts.look_end && sts.cmd != CMD_READ;
						ctl.scan_clr  = !sts.found && sts.look_end;
					end
					CMD_ALLOC, CMD_FLUSH: ctl.scan_clr = 1'b1;
					default: ctl.act_unk = 1'b1;
				endcase
			end
			S_SWEEP: begin
				ctl.sweep_step = 1'b1;
				ctl.act_load   = sts.taken;
				ctl.act_full   = !sts.taken && sts.sweep_end;
			end
			S_FLUSH: begin
				ctl.flush_step = 1'b1;
			end
			S_DONE: begin
				ctl.flush_done = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### hdl/cbfm_dp.sv
module cbfm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cbfm_pkg::CFG_BITS-1:0] cfg_data,
	input  logic [2:0]                    command,
	input  logic [7:0]                    file_id,
	input  logic [31:0]                   page_id,
	input  logic                          mark_dirty,
	input  cbfm_pkg::ctl_t                ctl,
	output cbfm_pkg::sts_t                sts,
	output logic                          result_valid,
	output logic [1:0]                    status,
	output logic [3:0]                    frame_index,
	output logic                          hit,
	output logic                          fetch_needed,
	output logic                          writeback_needed,
	output logic [7:0]                    writeback_file,
	output logic [31:0]                   writeback_page,
	output logic                          last
);
	import cbfm_pkg::*;

	logic [FILE_ID_BITS-1:0]   tag_file_q [NUM_FRAMES];
	logic [PAGE_BITS-1:0]      tag_page_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]     valid_q, dirty_q, ref_q;
	logic [PIN_COUNT_BITS-1:0] pin_q [NUM_FRAMES];
	logic [FRAME_BITS-1:0]     hand_q;
	logic [CFG_BITS-1:0]       fiu_q;

	logic [2:0]              cmd_q;
	logic [FILE_ID_BITS-1:0] file_q;
	logic [PAGE_BITS-1:0]    page_q;
	logic                    md_q;
	logic [STEP_BITS-1:0]    idx_q;   // scan index / sweep step count

	logic [CFG_BITS-1:0]   n_act;
	logic [FRAME_BITS-1:0] idx_f, hnext, last_f;
	logic                  match_c, hold_c, sel_c, flush_emit_c;
	logic [STEP_BITS-1:0]  two_n;

	// flush result held until the next one is known, so last can be set
	logic                     held_q;
	logic [1:0]               h_status_q;
	logic [OUT_FRAME_BITS-1:0] h_frame_q;
	logic                     h_wb_q;
	logic [OUT_FILE_BITS-1:0] h_wf_q;
	logic [PAGE_BITS-1:0]     h_wp_q;

	logic                      res_valid, res_hit, res_fetch, res_wb, res_last;
	logic [1:0]                res_status;
	logic [OUT_FRAME_BITS-1:0] res_frame;
	logic [OUT_FILE_BITS-1:0]  res_wf;
	logic [PAGE_BITS-1:0]      res_wp;

	always_comb begin
		if (fiu_q == '0) n_act = CFG_BITS'(1);
		else if (fiu_q > NF_CFG) n_act = NF_CFG;
		else n_act = fiu_q;
		last_f = FRAME_BITS'(n_act - CFG_BITS'(1));
		two_n  = STEP_BITS'({n_act, 1'b0});
		idx_f  = idx_q[FRAME_BITS-1:0];
		hnext  = (hand_q >= last_f) ? '0 : hand_q + FRAME_BITS'(1);
		sel_c   = valid_q[idx_f] && tag_file_q[idx_f] == file_q;
		match_c = sel_c && tag_page_q[idx_f] == page_q;
		hold_c  = valid_q[hnext] && (ref_q[hnext] || pin_q[hnext] != '0);
		flush_emit_c = ctl.flush_step && sel_c && (pin_q[idx_f] != '0 || dirty_q[idx_f]);
	end

	always_comb begin
		sts.cmd        = cmd_q;
		sts.found      = match_c;
		sts.look_end   = (idx_f == last_f);
		sts.taken      = !hold_c;
		sts.sweep_end  = (idx_q == two_n - STEP_BITS'(1));
		sts.flush_stop = sel_c && pin_q[idx_f] != '0;
		sts.flush_last = (idx_f == last_f);
	end

	always_comb begin
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_frame  = '0;
		res_hit    = 1'b0;
		res_fetch  = 1'b0;
		res_wb     = 1'b0;
		res_wf     = '0;
		res_wp     = '0;
		res_last   = 1'b1;
		if (ctl.act_hit) begin
			res_valid = 1'b1;
			res_frame = OUT_FRAME_BITS'(idx_f);
			res_hit   = 1'b1;
			if (cmd_q == CMD_UNPIN && pin_q[idx_f] == '0) res_status = ST_NOT_PIN;
		end else if (ctl.act_miss || ctl.act_unk) begin
			res_valid = 1'b1;
		end else if (ctl.act_full) begin
			res_valid  = 1'b1;
			res_status = ST_EXCEEDED;
		end else if (ctl.act_load) begin
			res_valid = 1'b1;
			res_frame = OUT_FRAME_BITS'(hnext);
			res_fetch = 1'b1;
			res_wb    = valid_q[hnext] && dirty_q[hnext];
			if (valid_q[hnext] && dirty_q[hnext]) begin
				res_wf = OUT_FILE_BITS'(tag_file_q[hnext]);
				res_wp = tag_page_q[hnext];
			end
		end else if ((flush_emit_c && held_q) || ctl.flush_done) begin
			// release the held flush result: without last if another follows, with last on flush_done
			res_valid  = 1'b1;
			res_status = h_status_q;
			res_frame  = h_frame_q;
			res_wb     = h_wb_q;
			res_wf     = h_wf_q;
			res_wp     = h_wp_q;
			res_last   = ctl.flush_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q   <= NF_CFG;
			hand_q  <= FRAME_BITS'(NUM_FRAMES - 1);
			valid_q <= '0;
			dirty_q <= '0;
			ref_q   <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) pin_q[i] <= '0;
			idx_q      <= '0;
			held_q     <= 1'b0;
			h_status_q <= ST_OK;
			h_frame_q  <= '0;
			h_wb_q     <= 1'b0;
			h_wf_q     <= '0;
			h_wp_q     <= '0;
			result_valid     <= 1'b0;
			status           <= ST_OK;
			frame_index      <= '0;
			hit              <= 1'b0;
			fetch_needed     <= 1'b0;
			writeback_needed <= 1'b0;
			writeback_file   <= '0;
			writeback_page   <= '0;
			last             <= 1'b0;
		end else begin
			if (cfg_we) fiu_q <= cfg_data;
			if (ctl.scan_clr) idx_q <= '0;
			else if (ctl.look_step || ctl.sweep_step || ctl.flush_step)
				idx_q <= idx_q + STEP_BITS'(1);

			if (ctl.act_hit) begin
				case (cmd_q)
					CMD_READ: begin
						ref_q[idx_f] <= 1'b1;
						if (pin_q[idx_f] != PIN_MAX) pin_q[idx_f] <= pin_q[idx_f] + 1'b1;
					end
					CMD_UNPIN: begin
						if (md_q) dirty_q[idx_f] <= 1'b1;
						if (pin_q[idx_f] != '0) pin_q[idx_f] <= pin_q[idx_f] - 1'b1;
					end
					default: begin
						valid_q[idx_f] <= 1'b0; dirty_q[idx_f] <= 1'b0;
						ref_q[idx_f] <= 1'b0; pin_q[idx_f] <= '0;
					end
				endcase
			end else if (ctl.sweep_step) begin
				hand_q <= hnext;
				if (ctl.act_load) begin
					valid_q[hnext] <= 1'b1; dirty_q[hnext] <= 1'b0;
					ref_q[hnext] <= 1'b1; pin_q[hnext] <= PIN_COUNT_BITS'(1);
				end else if (valid_q[hnext] && ref_q[hnext]) begin
					ref_q[hnext] <= 1'b0;
				end
			end else if (ctl.flush_step && sel_c && pin_q[idx_f] == '0) begin
				valid_q[idx_f] <= 1'b0; dirty_q[idx_f] <= 1'b0;
				ref_q[idx_f] <= 1'b0; pin_q[idx_f] <= '0;
			end

			if (ctl.capture) begin
				held_q     <= 1'b0;
				h_status_q <= ST_OK;
				h_frame_q  <= '0;
				h_wb_q     <= 1'b0;
				h_wf_q     <= '0;
				h_wp_q     <= '0;
			end else if (flush_emit_c) begin
				held_q     <= 1'b1;
				h_status_q <= (pin_q[idx_f] != '0) ? ST_PINNED : ST_OK;
				h_frame_q  <= OUT_FRAME_BITS'(idx_f);
				h_wb_q     <= (pin_q[idx_f] == '0);
				h_wf_q     <= (pin_q[idx_f] == '0) ? OUT_FILE_BITS'(tag_file_q[idx_f]) : '0;
				h_wp_q     <= (pin_q[idx_f] == '0) ? tag_page_q[idx_f] : '0;
			end

			result_valid <= res_valid;
			if (res_valid) begin
				status           <= res_status;
				frame_index      <= res_frame;
				hit              <= res_hit;
				fetch_needed     <= res_fetch;
				writeback_needed <= res_wb;
				writeback_file   <= res_wf;
				writeback_page   <= res_wp;
				last             <= res_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= command;
			file_q <= FILE_ID_BITS'(file_id);
			page_q <= page_id;
			md_q   <= mark_dirty;
		end
		if (ctl.act_load) begin
			tag_file_q[hnext] <= file_q;
			tag_page_q[hnext] <= page_q;
		end
	end

endmodule

### hdl/clock_buffer_frame_manager_unit.sv
// Clock-replacement buffer frame manager. Pulse start with a command while busy is low; the
// item is taken at that edge. Each result appears for one cycle with result_valid high and
// must be taken then; the receiver cannot stall. With n frames in use, busy stays high while:
// read, unpin and dispose scan the frames from 0 and stop at the first match; a read miss
// then sweeps at most 2n frames from the hand, as allocate does; flush scans the frames and
// stops early at a pinned frame of its file. The final result shows in the cycle in which
// busy drops, and the next command can be taken in that cycle; no command takes longer than
// a read miss. Flush gives one result per dirty frame of its file, one for a pinned frame at
// which it stops, or one empty result if there is none, each released once the next one is
// known. The frame table is held in flip-flops; no clearing pass follows reset.
module clock_buffer_frame_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [7:0]  file_id,
	input  logic [31:0] page_id,
	input  logic        mark_dirty,
	input  logic        cfg_we,
	input  logic [cbfm_pkg::CFG_BITS-1:0] cfg_data,
	output logic        result_valid,
	output logic [1:0]  status,
	output logic [3:0]  frame_index,
	output logic        hit,
	output logic        fetch_needed,
	output logic        writeback_needed,
	output logic [7:0]  writeback_file,
	output logic [31:0] writeback_page,
	output logic        last
);
	import cbfm_pkg::*;

	ctl_t ctl;
	sts_t sts;

	cbfm_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .sts, .ctl);

	cbfm_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_data, .command, .file_id, .page_id, .mark_dirty,
		.ctl, .sts, .result_valid, .status, .frame_index, .hit, .fetch_needed,
		.writeback_needed, .writeback_file, .writeback_page, .last
	);

endmodule

### hdl/cbfm_checker.sv
module cbfm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic       last,
	input logic [1:0] status,
	input logic       hit,
	input logic       fetch_needed
);
	import cbfm_pkg::*;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after start");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result while idle");

	a_exceeded_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_EXCEEDED |-> !hit && !fetch_needed && last)
		else $error("bad exceeded result");

	a_hit_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(hit && fetch_needed)) else $error("hit with fetch");

endmodule

bind clock_buffer_frame_manager_unit cbfm_checker u_chk (
	.clk, .arst_n, .start, .busy, .result_valid, .last, .status, .hit, .fetch_needed
);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import cbfm_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic [3:0]  frame;
		logic        hit;
		logic        fetch;
		logic        wb;
		logic [7:0]  wb_file;
		logic [31:0] wb_page;
		logic        last;
	} frame_result_t;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 2 * NUM_FRAMES + 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  command;
	logic [7:0]  file_id;
	logic [31:0] page_id;
	logic        mark_dirty;
	logic        cfg_we;
	logic [CFG_BITS-1:0] cfg_data;
	logic        result_valid;
	logic [1:0]  status;
	logic [3:0]  frame_index;
	logic        hit;
	logic        fetch_needed;
	logic        writeback_needed;
	logic [7:0]  writeback_file;
	logic [31:0] writeback_page;
	logic        last;

	// frame table mirror
	logic [7:0]  mir_file [NUM_FRAMES];
	logic [31:0] mir_page [NUM_FRAMES];
	logic        mir_valid [NUM_FRAMES];
	logic        mir_dirty [NUM_FRAMES];
	logic        mir_ref [NUM_FRAMES];
	logic [7:0]  mir_pins [NUM_FRAMES];
	logic [3:0]  mir_hand;
	logic [4:0]  frames_reg;

	frame_result_t pending_results[$];
	int          error_count;
	int          quiet_cycles;
	bit          idle_on;

	clock_buffer_frame_manager_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .file_id(file_id), .page_id(page_id),
		.mark_dirty(mark_dirty), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.result_valid(result_valid), .status(status), .frame_index(frame_index),
		.hit(hit), .fetch_needed(fetch_needed), .writeback_needed(writeback_needed),
		.writeback_file(writeback_file), .writeback_page(writeback_page), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int active_frames();
		if (frames_reg < 1) return 1;
		if (frames_reg > NUM_FRAMES) return NUM_FRAMES;
		return frames_reg;
	endfunction

	function automatic int lookup_frame(logic [7:0] f, logic [31:0] p);
		for (int i = 0; i < active_frames(); i++)
			if (mir_valid[i] && mir_file[i] == f && mir_page[i] == p) return i;
		return -1;
	endfunction

	function automatic frame_result_t blank_result();
		frame_result_t r;
		r = '{ST_OK, 4'd0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd0, 1'b1};
		return r;
	endfunction

	function automatic void drop_frame(int i);
		mir_valid[i] = 1'b0;
		mir_dirty[i] = 1'b0;
		mir_ref[i] = 1'b0;
		mir_pins[i] = '0;
	endfunction

	// second-chance sweep, then refill the victim or report the buffer exceeded
	function automatic frame_result_t load_victim(logic [7:0] f, logic [31:0] p);
		frame_result_t r;
		int n, h, victim;
		r = blank_result();
		n = active_frames();
		victim = -1;
		for (int s = 0; s < 2 * n && victim < 0; s++) begin
			h = int'(mir_hand) + 1;
			if (h >= n) h = 0;
			mir_hand = h[3:0];
			if (!mir_valid[h]) victim = h;
			else if (mir_ref[h]) mir_ref[h] = 1'b0;
			else if (mir_pins[h] == 0) victim = h;
		end
		if (victim < 0) begin
			r.status = ST_EXCEEDED;
			return r;
		end
		r.frame = victim[3:0];
		r.fetch = 1'b1;
		if (mir_valid[victim] && mir_dirty[victim]) begin
			r.wb = 1'b1;
			r.wb_file = mir_file[victim];
			r.wb_page = mir_page[victim];
		end
		mir_file[victim] = f;
		mir_page[victim] = p;
		mir_valid[victim] = 1'b1;
		mir_dirty[victim] = 1'b0;
		mir_ref[victim] = 1'b1;
		mir_pins[victim] = 8'd1;
		return r;
	endfunction

	function automatic void predict_command(logic [2:0] c, logic [7:0] f, logic [31:0] p,
			logic md);
		frame_result_t r;
		frame_result_t flushed[$];
		int i;
		bit stopped;
		r = blank_result();
		case (c)
			CMD_READ: begin
				i = lookup_frame(f, p);
				if (i < 0) r = load_victim(f, p);
				else begin
					mir_ref[i] = 1'b1;
					if (mir_pins[i] != 8'hff) mir_pins[i]++;
					r.frame = i[3:0];
					r.hit = 1'b1;
				end
				pending_results.push_back(r);
			end
			CMD_UNPIN: begin
				i = lookup_frame(f, p);
				if (i >= 0) begin
					if (md) mir_dirty[i] = 1'b1;
					r.frame = i[3:0];
					r.hit = 1'b1;
					if (mir_pins[i] == 0) r.status = ST_NOT_PIN;
					else mir_pins[i]--;
				end
				pending_results.push_back(r);
			end
			CMD_ALLOC: pending_results.push_back(load_victim(f, p));
			CMD_DISPOSE: begin
				i = lookup_frame(f, p);
				if (i >= 0) begin
					drop_frame(i);
					r.frame = i[3:0];
					r.hit = 1'b1;
				end
				pending_results.push_back(r);
			end
			CMD_FLUSH: begin
				stopped = 1'b0;
				for (int j = 0; j < active_frames() && !stopped; j++) begin
					if (mir_valid[j] && mir_file[j] == f) begin
						r = blank_result();
						r.frame = j[3:0];
						if (mir_pins[j] != 0) begin
							r.status = ST_PINNED;
							flushed.push_back(r);
							stopped = 1'b1;
						end else begin
							if (mir_dirty[j]) begin
								r.wb = 1'b1;
								r.wb_file = mir_file[j];
								r.wb_page = mir_page[j];
								flushed.push_back(r);
							end
							drop_frame(j);
						end
					end
				end
				if (flushed.size() == 0) flushed.push_back(blank_result());
				foreach (flushed[k]) begin
					flushed[k].last = (k == flushed.size() - 1);
					pending_results.push_back(flushed[k]);
				end
			end
			default: pending_results.push_back(r);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (frame_index !== e.frame) report_mismatch("frame_index", frame_index, e.frame);
				if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
				if (fetch_needed !== e.fetch) report_mismatch("fetch_needed", fetch_needed, e.fetch);
				if (writeback_needed !== e.wb)
					report_mismatch("writeback_needed", writeback_needed, e.wb);
				if (writeback_file !== e.wb_file)
					report_mismatch("writeback_file", writeback_file, e.wb_file);
				if (writeback_page !== e.wb_page)
					report_mismatch("writeback_page", writeback_page, e.wb_page);
				if (last !== e.last) report_mismatch("last", last, e.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("clock_buffer_frame_manager_unit verification failed");
			$finish;
		end
	end

	// start stays high between back-to-back items; only idle or drain lowers it
	task automatic send_item(input logic [2:0] c, input logic [7:0] f, input logic [31:0] p,
			input logic md);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		command <= c;
		file_id <= f;
		page_id <= p;
		mark_dirty <= md;
		do @(posedge clk); while (busy);
		predict_command(c, f, p, md);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frames(input logic [4:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_reg = v;
	endtask

	task automatic test_basic_commands();
		set_frames(5'd16);
		send_item(CMD_READ, 8'hff, 32'hffff_ffff, 1'b0);
		send_item(CMD_READ, 8'h00, 32'h0000_0000, 1'b1);
		send_item(CMD_READ, 8'hff, 32'hffff_ffff, 1'b0);
		send_item(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1'b1);
		send_item(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1'b0);
		send_item(CMD_UNPIN, 8'hff, 32'hffff_ffff, 1'b0);
		send_item(CMD_UNPIN, 8'h12, 32'h5, 1'b1);
		send_item(CMD_ALLOC, 8'h00, 32'h0000_0000, 1'b0);
		send_item(CMD_DISPOSE, 8'h00, 32'h0000_0000, 1'b0);
		send_item(CMD_DISPOSE, 8'h00, 32'h0000_0000, 1'b0);
		send_item(CMD_DISPOSE, 8'h33, 32'h7, 1'b0);
		send_item(3'd5, 8'haa, 32'h5555_aaaa, 1'b1);
		send_item(3'd6, 8'h55, 32'haaaa_5555, 1'b0);
		send_item(3'd7, 8'h01, 32'h1, 1'b1);
	endtask

	task automatic test_flush();
		send_item(CMD_ALLOC, 8'h07, 32'h10, 1'b0);
		send_item(CMD_ALLOC, 8'h07, 32'h11, 1'b0);
		send_item(CMD_ALLOC, 8'h07, 32'h12, 1'b0);
		send_item(CMD_UNPIN, 8'h07, 32'h10, 1'b1);
		send_item(CMD_UNPIN, 8'h07, 32'h11, 1'b0);
		send_item(CMD_FLUSH, 8'h07, 32'h0, 1'b0);
		send_item(CMD_UNPIN, 8'h07, 32'h12, 1'b1);
		send_item(CMD_FLUSH, 8'h07, 32'h0, 1'b0);
		send_item(CMD_FLUSH, 8'h07, 32'h0, 1'b0);
	endtask

	task automatic test_buffer_full();
		set_frames(5'd2);
		send_item(CMD_ALLOC, 8'h01, 32'h1, 1'b0);
		send_item(CMD_ALLOC, 8'h01, 32'h1, 1'b0);
		send_item(CMD_READ, 8'h01, 32'h2, 1'b0);
		send_item(CMD_UNPIN, 8'h01, 32'h1, 1'b1);
		send_item(CMD_READ, 8'h01, 32'h3, 1'b0);
	endtask

	task automatic test_pin_saturation();
		set_frames(5'd0);
		for (int i = 0; i < 257; i++) send_item(CMD_READ, 8'h09, 32'h99, 1'b0);
		send_item(CMD_DISPOSE, 8'h09, 32'h99, 1'b0);
	endtask

	task automatic test_random_mix(input logic [4:0] frames, input int count);
		logic [2:0] c;
		logic [7:0] f;
		logic [31:0] p;
		int pick;
		set_frames(frames);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 38) c = CMD_READ;
			else if (pick < 70) c = CMD_UNPIN;
			else if (pick < 82) c = CMD_ALLOC;
			else if (pick < 91) c = CMD_DISPOSE;
			else if (pick < 97) c = CMD_FLUSH;
			else c = 3'($urandom_range(5, 7));
			f = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
			p = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 7));
			send_item(c, f, p, 1'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		file_id = '0;
		page_id = '0;
		mark_dirty = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		error_count = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		frames_reg = 5'd16;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			drop_frame(i);
			mir_file[i] = '0;
			mir_page[i] = '0;
		end
		mir_hand = 4'(NUM_FRAMES - 1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_flush();
		test_buffer_full();
		test_pin_saturation();
		test_random_mix(5'd16, 30);
		test_random_mix(5'd4, 16);
		test_random_mix(5'd31, 12);
		test_random_mix(5'd1, 8);
		idle_on = 1'b0;
		test_random_mix(5'd7, 18);
		drain_results();

		if (error_count == 0) $display("clock_buffer_frame_manager_unit verification clean");
		else $display("clock_buffer_frame_manager_unit verification failed");
		$finish;
	end

endmodule
